// ----- rtl/rsos_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsos_pkg
// Shared constants, codes and types of the range sweep object segmenter.
// ----------------------------------------------------------------------------
package rsos_pkg;

    localparam int SWEEP_SAMPLES = 128;
    localparam int IDX_W         = $clog2(SWEEP_SAMPLES);
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(SWEEP_SAMPLES - 1);

    localparam int DIST_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ANGLE_STEP     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FORWARD_ANGLE  = 2'd2;

    localparam logic [15:0] RESET_NEAR_THRESHOLD = 16'd1600;
    localparam logic [1:0]  RESET_ANGLE_STEP     = 2'd2;
    localparam logic [7:0]  RESET_FORWARD_ANGLE  = 8'd90;

    localparam logic [7:0] RUN_LEN_MAX = 8'd255;
    localparam logic [6:0] COUNT_MAX   = 7'd127;
    localparam logic [5:0] NUMBER_MAX  = 6'd63;
    localparam logic [9:0] ANGLE_MAX   = 10'd254;
    localparam logic [9:0] WIDTH_MAX   = 10'd256;

    localparam logic KIND_REPORT  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic              valid;
        logic              close;
        logic              last;
        logic              upd;
        logic              fwd;
        logic [DIST_W-1:0] fwd_data;
        logic [5:0]        rep_num;
        logic [7:0]        rep_ang;
        logic [8:0]        rep_wid;
        logic              found;
        logic [5:0]        sum_num;
        logic [7:0]        sum_ang;
        logic [8:0]        sum_wid;
        logic [8:0]        turn;
    } stage_t;

    typedef struct packed {
        logic              has_rep;
        logic              has_sum;
        logic [5:0]        rep_num;
        logic [7:0]        rep_ang;
        logic [8:0]        rep_wid;
        logic [DIST_W-1:0] rep_dist;
        logic              found;
        logic [5:0]        sum_num;
        logic [7:0]        sum_ang;
        logic [8:0]        sum_wid;
        logic [DIST_W-1:0] sum_dist;
        logic [8:0]        turn;
    } bundle_t;

endpackage
`default_nettype wire

// ----- rtl/range_sweep_object_segmenter_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// range_sweep_object_segmenter_core
// Splits one angular range sweep into objects and picks the narrowest.
//
// Samples enter on sample_valid / sample_ready, one request per cycle when
// not stalled. Each sample is written to the line store; a sample that ends a
// run reads the run's center entry back on the single read port, one read
// per sample, so the sustained input rate is one sample per cycle.
// A sample causes zero, one or two results (object report, then end-of-sweep
// summary on the last sample). The first result of a sample passes the stage
// register and the queue before it shows on result_valid; a second result
// follows in the cycle after the first is taken, so two-result samples
// drain at one result per cycle while result_ready is high.
// Results wait in a four-entry queue. While result_ready is low the front
// result holds and samples keep entering until the queue and the read stage
// together reach four entries; then sample_ready drops.
// Reset clears run state, the queue and the configuration to its defaults;
// the line store is not cleared, every entry is written before it is read.
// Configuration writes on cfg_wen take effect at once, no wait states.
// ----------------------------------------------------------------------------
module range_sweep_object_segmenter_core
    import rsos_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  sample_valid,
    output logic                       sample_ready,
    input  wire logic [DIST_W-1:0]     distance,
    input  wire logic                  last,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output logic                       kind,
    output logic      [5:0]            object_number,
    output logic      [7:0]            center_angle,
    output logic      [8:0]            angular_width,
    output logic      [DIST_W-1:0]     object_distance,
    output logic                       found,
    output logic signed [8:0]          turn_angle,
    output logic                       end_of_run
);

    logic              accept;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [DIST_W-1:0] mem_rdata;
    stage_t            stage;

    assign accept = sample_valid && sample_ready;

    rsos_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .distance  (distance),
        .last      (last),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .stage     (stage)
    );

    rsos_store u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (distance),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rsos_outq u_outq (
        .clk             (clk),
        .rst_n           (rst_n),
        .stage           (stage),
        .rdata           (mem_rdata),
        .sample_ready    (sample_ready),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .kind            (kind),
        .object_number   (object_number),
        .center_angle    (center_angle),
        .angular_width   (angular_width),
        .object_distance (object_distance),
        .found           (found),
        .turn_angle      (turn_angle),
        .end_of_run      (end_of_run)
    );

endmodule
`default_nettype wire

// ----- rtl/rsos_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsos_store
// Line store of one sweep: one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsos_store
    import rsos_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [IDX_W-1:0]  waddr,
    input  wire logic [DIST_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [IDX_W-1:0]  raddr,
    output logic      [DIST_W-1:0] rdata
);

    logic [DIST_W-1:0] mem [SWEEP_SAMPLES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rsos_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsos_tracker
// Configuration registers, run tracking and narrowest-object selection.
// Drives the line store and registers the per-sample outcome.
// ----------------------------------------------------------------------------
module rsos_tracker
    import rsos_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wen,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  accept,
    input  wire logic [DIST_W-1:0]     distance,
    input  wire logic                  last,
    output logic                       mem_we,
    output logic      [IDX_W-1:0]      mem_waddr,
    output logic                       mem_re,
    output logic      [IDX_W-1:0]      mem_raddr,
    output stage_t                     stage
);

    logic [15:0]      near_threshold_reg;
    logic [1:0]       angle_step_reg;
    logic [7:0]       forward_angle_reg;

    logic [IDX_W-1:0] sample_index_reg;
    logic             in_run_reg;
    logic [IDX_W-1:0] run_start_reg;
    logic [7:0]       run_length_reg;
    logic [6:0]       object_count_reg;
    logic             best_valid_reg;
    logic [5:0]       best_number_reg;
    logic [8:0]       best_width_reg;
    logic [7:0]       best_angle_reg;

    logic             stage_valid_reg;
    stage_t           stage_reg;
    stage_t           stage_next;

    logic             occ;
    logic             step_two;
    logic [IDX_W-1:0] start_c;
    logic [7:0]       len_c;
    logic             close_c;
    logic [8:0]       center_sum;
    logic [IDX_W-1:0] center_c;
    logic [9:0]       ang_base;
    logic [9:0]       ang_raw;
    logic [7:0]       ang_c;
    logic [9:0]       wid_base;
    logic [9:0]       wid_raw;
    logic [8:0]       wid_c;
    logic [5:0]       num_c;
    logic             upd_c;
    logic             found_c;
    logic [5:0]       sum_num_c;
    logic [7:0]       sum_ang_c;
    logic [8:0]       sum_wid_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_threshold_reg <= RESET_NEAR_THRESHOLD;
            angle_step_reg     <= RESET_ANGLE_STEP;
            forward_angle_reg  <= RESET_FORWARD_ANGLE;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                CFG_NEAR_THRESHOLD: near_threshold_reg <= cfg_wdata[15:0];
                CFG_ANGLE_STEP:     angle_step_reg     <= cfg_wdata[1:0];
                CFG_FORWARD_ANGLE:  forward_angle_reg  <= cfg_wdata[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        occ      = distance <= near_threshold_reg;
        step_two = angle_step_reg[1];

        start_c = (occ && !in_run_reg) ? sample_index_reg : run_start_reg;
        if (occ && !in_run_reg)
        begin
            len_c = 8'd1;
        end
        else if (occ && run_length_reg != RUN_LEN_MAX)
        begin
            len_c = run_length_reg + 8'd1;
        end
        else
        begin
            len_c = run_length_reg;
        end
        close_c = (!occ && in_run_reg) || (occ && last);

        center_sum = 9'(start_c) + 9'(len_c[7:1]);
        center_c   = (center_sum > 9'(LAST_INDEX)) ? LAST_INDEX : center_sum[IDX_W-1:0];

        ang_base = 10'(center_c);
        ang_raw  = step_two ? (ang_base << 1) : ang_base;
        ang_c    = (ang_raw > ANGLE_MAX) ? ANGLE_MAX[7:0] : ang_raw[7:0];

        wid_base = 10'(len_c);
        wid_raw  = step_two ? (wid_base << 1) : wid_base;
        wid_c    = (wid_raw > WIDTH_MAX) ? WIDTH_MAX[8:0] : wid_raw[8:0];

        num_c = (object_count_reg > 7'(NUMBER_MAX)) ? NUMBER_MAX : object_count_reg[5:0];
        upd_c = close_c && (!best_valid_reg || wid_c < best_width_reg);

        found_c   = best_valid_reg || close_c;
        sum_num_c = 6'd0;
        sum_ang_c = 8'd0;
        sum_wid_c = 9'd0;
        if (found_c)
        begin
            sum_num_c = upd_c ? num_c : best_number_reg;
            sum_ang_c = upd_c ? ang_c : best_angle_reg;
            sum_wid_c = upd_c ? wid_c : best_width_reg;
        end

        stage_next.valid    = 1'b1;
        stage_next.close    = close_c;
        stage_next.last     = last;
        stage_next.upd      = upd_c;
        stage_next.fwd      = center_c == sample_index_reg;
        stage_next.fwd_data = distance;
        stage_next.rep_num  = num_c;
        stage_next.rep_ang  = ang_c;
        stage_next.rep_wid  = wid_c;
        stage_next.found    = found_c;
        stage_next.sum_num  = sum_num_c;
        stage_next.sum_ang  = sum_ang_c;
        stage_next.sum_wid  = sum_wid_c;
        stage_next.turn     = found_c ? (9'(forward_angle_reg) - 9'(sum_ang_c)) : 9'd0;

        mem_we    = accept;
        mem_waddr = sample_index_reg;
        mem_re    = accept && close_c;
        mem_raddr = center_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_index_reg <= '0;
            in_run_reg       <= 1'b0;
            run_start_reg    <= '0;
            run_length_reg   <= 8'd0;
            object_count_reg <= 7'd0;
            best_valid_reg   <= 1'b0;
            best_number_reg  <= 6'd0;
            best_width_reg   <= 9'd0;
            best_angle_reg   <= 8'd0;
        end
        else if (accept)
        begin
            if (last)
            begin
                sample_index_reg <= '0;
                in_run_reg       <= 1'b0;
                run_start_reg    <= '0;
                run_length_reg   <= 8'd0;
                object_count_reg <= 7'd0;
                best_valid_reg   <= 1'b0;
                best_number_reg  <= 6'd0;
                best_width_reg   <= 9'd0;
                best_angle_reg   <= 8'd0;
            end
            else
            begin
                in_run_reg <= occ;
                if (occ)
                begin
                    run_start_reg  <= start_c;
                    run_length_reg <= len_c;
                end
                if (close_c && object_count_reg != COUNT_MAX)
                begin
                    object_count_reg <= object_count_reg + 7'd1;
                end
                if (upd_c)
                begin
                    best_valid_reg  <= 1'b1;
                    best_number_reg <= num_c;
                    best_width_reg  <= wid_c;
                    best_angle_reg  <= ang_c;
                end
                if (sample_index_reg != LAST_INDEX)
                begin
                    sample_index_reg <= sample_index_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        stage       = stage_reg;
        stage.valid = stage_valid_reg;
    end

endmodule
`default_nettype wire

// ----- rtl/rsos_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsos_outq
// Joins store read data to the registered sample outcome, queues result
// bundles and serializes them onto the result channel.
// ----------------------------------------------------------------------------
module rsos_outq
    import rsos_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  stage_t                 stage,
    input  wire logic [DIST_W-1:0] rdata,
    output logic                   sample_ready,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output logic                   kind,
    output logic      [5:0]        object_number,
    output logic      [7:0]        center_angle,
    output logic      [8:0]        angular_width,
    output logic      [DIST_W-1:0] object_distance,
    output logic                   found,
    output logic signed [8:0]      turn_angle,
    output logic                   end_of_run
);

    logic [DIST_W-1:0] best_distance_reg;
    bundle_t           queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              sub_reg;

    logic [DIST_W-1:0] center_dist;
    bundle_t           bundle_in;
    bundle_t           head;
    logic              push;
    logic              pop;
    logic              show_sum;
    logic              take;

    always_comb
    begin
        center_dist = stage.fwd ? stage.fwd_data : rdata;

        bundle_in.has_rep  = stage.close;
        bundle_in.has_sum  = stage.last;
        bundle_in.rep_num  = stage.rep_num;
        bundle_in.rep_ang  = stage.rep_ang;
        bundle_in.rep_wid  = stage.rep_wid;
        bundle_in.rep_dist = center_dist;
        bundle_in.found    = stage.found;
        bundle_in.sum_num  = stage.sum_num;
        bundle_in.sum_ang  = stage.sum_ang;
        bundle_in.sum_wid  = stage.sum_wid;
        if (!stage.found)
        begin
            bundle_in.sum_dist = '0;
        end
        else if (stage.upd)
        begin
            bundle_in.sum_dist = center_dist;
        end
        else
        begin
            bundle_in.sum_dist = best_distance_reg;
        end
        bundle_in.turn = stage.turn;

        push = stage.valid && (stage.close || stage.last);

        sample_ready = ((QCNT_W + 1)'(count_reg) + (QCNT_W + 1)'(stage.valid))
                       < (QCNT_W + 1)'(QUEUE_DEPTH);

        head         = queue[rd_ptr_reg];
        result_valid = count_reg != '0;
        show_sum     = !head.has_rep || sub_reg;
        end_of_run   = show_sum || !head.has_sum;
        take         = result_valid && result_ready;
        pop          = take && end_of_run;

        if (show_sum)
        begin
            kind            = KIND_SUMMARY;
            object_number   = head.sum_num;
            center_angle    = head.sum_ang;
            angular_width   = head.sum_wid;
            object_distance = head.sum_dist;
            found           = head.found;
            turn_angle      = head.turn;
        end
        else
        begin
            kind            = KIND_REPORT;
            object_number   = head.rep_num;
            center_angle    = head.rep_ang;
            angular_width   = head.rep_wid;
            object_distance = head.rep_dist;
            found           = 1'b0;
            turn_angle      = 9'sd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_distance_reg <= '0;
        end
        else if (stage.valid && stage.upd)
        begin
            best_distance_reg <= center_dist;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue[wr_ptr_reg] <= bundle_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (take)
            begin
                sub_reg <= !pop;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/rsos_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsos_checker
// Port-level checks of the segmenter result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rsos_checker
    import rsos_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  result_valid,
    input wire logic                  result_ready,
    input wire logic                  kind,
    input wire logic [5:0]            object_number,
    input wire logic [7:0]            center_angle,
    input wire logic [8:0]            angular_width,
    input wire logic [DIST_W-1:0]     object_distance,
    input wire logic                  found,
    input wire logic signed [8:0]     turn_angle,
    input wire logic                  end_of_run
);

    // hold a stalled request
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(kind)
            && $stable(object_number) && $stable(center_angle)
            && $stable(angular_width) && $stable(object_distance)
            && $stable(found) && $stable(turn_angle) && $stable(end_of_run))
        else $error("stalled result changed");

    // only a report can be followed by a second result of the same sample
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !end_of_run |-> kind == KIND_REPORT)
        else $error("summary not last of its sample");

    // the summary follows its report in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !end_of_run |=> result_valid && kind == KIND_SUMMARY)
        else $error("summary did not follow report");

    // an empty sweep reports all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == KIND_SUMMARY && !found |->
            object_number == 6'd0 && center_angle == 8'd0 && angular_width == 9'd0
            && object_distance == '0 && turn_angle == 9'sd0)
        else $error("empty summary not zero");

endmodule

bind range_sweep_object_segmenter_core rsos_checker u_rsos_checker (.*);
`default_nettype wire
